/* rtl/ckx_pkg.sv */
// Shared types and constants of the ChaCha20 keystream XOR unit.
`default_nettype none
package ckx_pkg;

  // The four ChaCha constant words, "expand 32-byte k".
  localparam logic [31:0] SIGMA [4] = '{32'h61707865, 32'h3320646e,
                                        32'h79622d32, 32'h6b206574};

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_0   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_1   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_2   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD_3   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_NONCE_VALUE  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_COUNT  = 3'd5;

  // One classified request on its way from the front part to the back part.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [5:0]  offset;
    logic        need_block;
    logic [63:0] counter;
  } ckx_entry_t;

  // Key material that the block generator reads.
  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce;
  } ckx_key_t;

  // Load of the start counter from the configuration port.
  typedef struct packed {
    logic        load;
    logic [63:0] value;
  } ckx_cfg_load_t;

  // Back part sequencer states.
  typedef enum logic [1:0] {
    BK_SERVE,
    BK_ROUND,
    BK_ADD
  } ckx_back_state_t;

  // Rotate a word left by a nonzero amount.
  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
    return (v << n) | (v >> (6'd32 - {1'b0, n}));
  endfunction

endpackage
`default_nettype wire

/* rtl/chacha20_keystream_xor_unit.sv */
// Top level of the ChaCha20 keystream XOR unit.
//
// Each accepted byte is XORed with the next byte of a ChaCha keystream and
// returned with its last-byte mark. Every message starts at the configured
// start counter, and a new 64-byte block is made for each byte at offset 0.
// Bytes inside a block come out at one per cycle while the receiver is
// ready. The first byte of each block waits for the block generator, which
// runs one quarter-round line (one 32-bit add, xor and rotate on all four
// quarter rounds) per cycle. The request queue of QUEUE_DEPTH entries lets
// the input side take up to QUEUE_DEPTH bytes meanwhile before it stalls.
// Configuration writes are taken in every cycle and must be made while the
// unit is idle; unused register indexes are ignored.
`default_nettype none
module chacha20_keystream_xor_unit
  import ckx_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = 20,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             in_data_byte,
  input  wire logic                   in_last_byte,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  out_byte,
  output logic                        out_last,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [63:0]            cfg_data
);

  logic [63:0]   key_word_r [4];
  logic [63:0]   nonce_r;
  logic          cfg_write;
  ckx_cfg_load_t cfg_load;
  ckx_key_t      key;
  ckx_entry_t    push_entry;
  ckx_entry_t    head;
  logic          push;
  logic          pop;
  logic          queue_full;
  logic          queue_empty;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // Start counter loads go to the front part.
  assign cfg_load.load  = cfg_write && (cfg_index == CFG_START_COUNT);
  assign cfg_load.value = cfg_data;

  // Key and nonce registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        key_word_r[i] <= '0;
      end
      nonce_r <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_KEY_WORD_0:  key_word_r[0] <= cfg_data;
        CFG_KEY_WORD_1:  key_word_r[1] <= cfg_data;
        CFG_KEY_WORD_2:  key_word_r[2] <= cfg_data;
        CFG_KEY_WORD_3:  key_word_r[3] <= cfg_data;
        CFG_NONCE_VALUE: nonce_r       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      key.key[i] = key_word_r[i];
    end
    key.nonce = nonce_r;
  end

  ckx_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .queue_full   (queue_full),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .cfg_load     (cfg_load),
    .push         (push),
    .push_entry   (push_entry)
  );

  ckx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head       (head),
    .empty      (queue_empty)
  );

  ckx_back #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .key       (key),
    .head      (head),
    .empty     (queue_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule
`default_nettype wire

/* rtl/ckx_queue.sv */
// Short request queue between the front part and the back part.
`default_nettype none
module ckx_queue
  import ckx_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire ckx_entry_t push_entry,
  output logic            full,
  input  wire logic       pop,
  output ckx_entry_t      head,
  output logic            empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ckx_entry_t       mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Pointer and fill count updates, wrapping at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

/* rtl/ckx_front.sv */
// Front part: accepts byte requests, tracks offset and block counter.
`default_nettype none
module ckx_front
  import ckx_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          queue_full,
  output logic               in_ready,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          in_last_byte,
  input  wire ckx_cfg_load_t cfg_load,
  output logic               push,
  output ckx_entry_t         push_entry
);

  logic [5:0]  byte_offset_r, byte_offset_nxt;
  logic [63:0] block_counter_r, block_counter_nxt;
  logic [63:0] start_counter_r, start_counter_nxt;
  logic        first_of_block;

  assign in_ready       = !queue_full;
  assign push           = in_valid && in_ready;
  assign first_of_block = (byte_offset_r == '0);

  // Classify the request: its place in the block and whether a block is due.
  always_comb begin
    push_entry.data       = in_data_byte;
    push_entry.last       = in_last_byte;
    push_entry.offset     = byte_offset_r;
    push_entry.need_block = first_of_block;
    push_entry.counter    = block_counter_r;
  end

  // Offset and counter advance; the last byte restarts the message.
  always_comb begin
    byte_offset_nxt   = byte_offset_r;
    block_counter_nxt = block_counter_r;
    start_counter_nxt = start_counter_r;
    if (push) begin
      byte_offset_nxt = byte_offset_r + 1'b1;
      if (first_of_block) begin
        block_counter_nxt = block_counter_r + 64'd1;
      end
      if (in_last_byte) begin
        byte_offset_nxt   = '0;
        block_counter_nxt = start_counter_r;
      end
    end
    if (cfg_load.load) begin
      start_counter_nxt = cfg_load.value;
      block_counter_nxt = cfg_load.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r   <= '0;
      block_counter_r <= '0;
      start_counter_r <= '0;
    end else begin
      byte_offset_r   <= byte_offset_nxt;
      block_counter_r <= block_counter_nxt;
      start_counter_r <= start_counter_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/ckx_back.sv */
// Back part: iterative ChaCha block generator and the output XOR stage.
`default_nettype none
module ckx_back
  import ckx_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = 20
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire ckx_key_t   key,
  input  wire ckx_entry_t head,
  input  wire logic       empty,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  localparam int unsigned RCW = $clog2(ROUND_COUNT);
  localparam logic [4:0] ROT_STEP0 = 5'd16;
  localparam logic [4:0] ROT_STEP1 = 5'd12;
  localparam logic [4:0] ROT_STEP2 = 5'd8;
  localparam logic [4:0] ROT_STEP3 = 5'd7;

  ckx_back_state_t state_r, state_nxt;
  logic [31:0]     w_r [16];
  logic [31:0]     ks_r [16];
  logic [31:0]     init_w [16];
  logic [31:0]     w_step [16];
  logic [1:0]      step_r;
  logic [RCW-1:0]  round_r;
  logic            gen_done_r;
  logic            out_valid_r;
  logic [7:0]      out_byte_r;
  logic            out_last_r;
  logic            out_free;
  logic            do_start;
  logic            last_step;
  logic [31:0]     ks_word;
  logic [7:0]      ks_byte;

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;
  assign out_free  = !out_valid_r || out_ready;
  assign last_step = (step_r == 2'd3) && (round_r == RCW'(ROUND_COUNT - 1));

  // Initial state words for the block of the request at the queue head.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      init_w[i]         = SIGMA[i];
      init_w[4 + 2 * i] = key.key[i][31:0];
      init_w[5 + 2 * i] = key.key[i][63:32];
    end
    init_w[12] = head.counter[31:0];
    init_w[13] = head.counter[63:32];
    init_w[14] = key.nonce[31:0];
    init_w[15] = key.nonce[63:32];
  end

  // One quarter-round line on all four quarter rounds: one add, xor, rotate.
  always_comb begin
    logic [3:0]  ia, ib, ic, id, ix, iy, iz;
    logic [4:0]  rot;
    logic [31:0] sum;
    for (int i = 0; i < 16; i++) begin
      w_step[i] = w_r[i];
    end
    for (int q = 0; q < 4; q++) begin
      ia = 4'(q);
      ib = round_r[0] ? 4'(4 + ((q + 1) & 3))  : 4'(4 + q);
      ic = round_r[0] ? 4'(8 + ((q + 2) & 3))  : 4'(8 + q);
      id = round_r[0] ? 4'(12 + ((q + 3) & 3)) : 4'(12 + q);
      case (step_r)
        2'd0: begin
          ix = ia; iy = ib; iz = id; rot = ROT_STEP0;
        end
        2'd1: begin
          ix = ic; iy = id; iz = ib; rot = ROT_STEP1;
        end
        2'd2: begin
          ix = ia; iy = ib; iz = id; rot = ROT_STEP2;
        end
        default: begin
          ix = ic; iy = id; iz = ib; rot = ROT_STEP3;
        end
      endcase
      sum        = w_r[ix] + w_r[iy];
      w_step[ix] = sum;
      w_step[iz] = rotl32(w_r[iz] ^ sum, rot);
    end
  end

  // Keystream byte for the request at the head.
  assign ks_word = ks_r[head.offset[5:2]];
  assign ks_byte = ks_word[{head.offset[1:0], 3'b000} +: 8];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_SERVE: begin
        if (do_start) begin
          state_nxt = BK_ROUND;
        end
      end
      BK_ROUND: begin
        if (last_step) begin
          state_nxt = BK_ADD;
        end
      end
      BK_ADD: begin
        state_nxt = BK_SERVE;
      end
      default: begin
        state_nxt = BK_SERVE;
      end
    endcase
  end

  // Sequencer outputs: start a block or hand the head request out.
  always_comb begin
    do_start = 1'b0;
    pop      = 1'b0;
    case (state_r)
      BK_SERVE: begin
        if (!empty) begin
          if (head.need_block && !gen_done_r) begin
            do_start = 1'b1;
          end else if (out_free) begin
            pop = 1'b1;
          end
        end
      end
      default: begin
        do_start = 1'b0;
        pop      = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_SERVE;
      step_r      <= '0;
      round_r     <= '0;
      gen_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_start) begin
        step_r  <= '0;
        round_r <= '0;
      end else if (state_r == BK_ROUND) begin
        step_r <= step_r + 1'b1;
        if (step_r == 2'd3) begin
          round_r <= round_r + 1'b1;
        end
      end
      if (state_r == BK_ADD) begin
        gen_done_r <= 1'b1;
      end else if (pop) begin
        gen_done_r <= 1'b0;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working state, keystream block and output payload.
  always_ff @(posedge clk) begin
    if (do_start) begin
      w_r <= init_w;
    end else if (state_r == BK_ROUND) begin
      w_r <= w_step;
    end
    if (state_r == BK_ADD) begin
      for (int i = 0; i < 16; i++) begin
        ks_r[i] <= w_r[i] + init_w[i];
      end
    end
    if (pop) begin
      out_byte_r <= head.data ^ ks_byte;
      out_last_r <= head.last;
    end
  end

endmodule
`default_nettype wire

/* tb/tb_chacha20_keystream_xor_unit.sv */
// Self-checking testbench for the ChaCha20 keystream XOR unit.
module tb_chacha20_keystream_xor_unit
  import ckx_pkg::*;
();

  localparam int ROUNDS = 20;
  localparam int RANDOM_ITEMS = 1930;
  localparam int QUIET_ITEMS = 300;
  localparam int SETTLE_CYCLES = 4 * ROUNDS + 20;
  localparam int CYCLE_LIMIT = 5000000;

  // Register indexes that the unit does not implement.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_6 = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_7 = 3'd7;

  // The four constant words, "expand 32-byte k".
  localparam logic [31:0] CHACHA_CONST [4] = '{32'h61707865, 32'h3320646e,
                                               32'h79622d32, 32'h6b206574};

  typedef logic [15:0][31:0] block_words_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [7:0]             in_data_byte = '0;
  logic                   in_last_byte = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [7:0]             out_byte;
  logic                   out_last;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [63:0]            cfg_data = '0;

  chacha20_keystream_xor_unit #(
    .ROUND_COUNT(ROUNDS)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Predicted state of the unit.
  logic [63:0]  cipher_key [4] = '{default: '0};
  logic [63:0]  cipher_nonce = '0;
  logic [63:0]  first_counter = '0;
  logic [63:0]  next_counter = '0;
  block_words_t key_block = '0;
  logic [5:0]   block_pos = '0;

  // Expected output bytes, oldest first.
  byte_result_t expected_bytes [$];
  byte_result_t head_result;

  int  fail_count = 0;
  int  cycle_count = 0;
  int  items_sent = 0;
  bit  idle_enable = 1'b1;
  int  gap_odds = 4;
  int  stall_odds = 4;
  int  stall_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run time guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL chacha20_keystream_xor_unit");
      $finish;
    end
  end

  function automatic logic [31:0] rotate_left(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic block_words_t quarter_round(input block_words_t w,
                                                 input int a, input int b,
                                                 input int c, input int d);
    w[a] = w[a] + w[b];
    w[d] = rotate_left(w[d] ^ w[a], 16);
    w[c] = w[c] + w[d];
    w[b] = rotate_left(w[b] ^ w[c], 12);
    w[a] = w[a] + w[b];
    w[d] = rotate_left(w[d] ^ w[a], 8);
    w[c] = w[c] + w[d];
    w[b] = rotate_left(w[b] ^ w[c], 7);
    return w;
  endfunction

  // One keystream block: rounds over the initial state, then the feed-forward add.
  function automatic block_words_t chacha_block(input logic [63:0] counter);
    block_words_t init_w;
    block_words_t work;
    for (int i = 0; i < 4; i++) begin
      init_w[i] = CHACHA_CONST[i];
      init_w[4 + 2 * i] = cipher_key[i][31:0];
      init_w[5 + 2 * i] = cipher_key[i][63:32];
    end
    init_w[12] = counter[31:0];
    init_w[13] = counter[63:32];
    init_w[14] = cipher_nonce[31:0];
    init_w[15] = cipher_nonce[63:32];
    work = init_w;
    for (int r = 0; r < ROUNDS; r++) begin
      if ((r % 2) == 0) begin
        work = quarter_round(work, 0, 4, 8, 12);
        work = quarter_round(work, 1, 5, 9, 13);
        work = quarter_round(work, 2, 6, 10, 14);
        work = quarter_round(work, 3, 7, 11, 15);
      end else begin
        work = quarter_round(work, 0, 5, 10, 15);
        work = quarter_round(work, 1, 6, 11, 12);
        work = quarter_round(work, 2, 7, 8, 13);
        work = quarter_round(work, 3, 4, 9, 14);
      end
    end
    for (int i = 0; i < 16; i++) begin
      work[i] = work[i] + init_w[i];
    end
    return work;
  endfunction

  // Advance the predicted stream by one byte and return the transformed byte.
  function automatic logic [7:0] xor_with_keystream(input logic [7:0] d, input logic l);
    logic [7:0] ks_byte;
    if (block_pos == 6'd0) begin
      key_block = chacha_block(next_counter);
      next_counter = next_counter + 64'd1;
    end
    ks_byte = key_block[block_pos[5:2]][8 * block_pos[1:0] +: 8];
    block_pos = block_pos + 6'd1;
    if (l) begin
      block_pos = 6'd0;
      next_counter = first_counter;
    end
    return d ^ ks_byte;
  endfunction

  // Apply a register write to the predicted state.
  function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [63:0] v);
    case (idx)
      CFG_KEY_WORD_0: cipher_key[0] = v;
      CFG_KEY_WORD_1: cipher_key[1] = v;
      CFG_KEY_WORD_2: cipher_key[2] = v;
      CFG_KEY_WORD_3: cipher_key[3] = v;
      CFG_NONCE_VALUE: cipher_nonce = v;
      CFG_START_COUNT: begin
        first_counter = v;
        next_counter = v;
      end
      default: ;
    endcase
  endfunction

  // Random 64-bit value with a bias toward the edges of the range.
  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return '1;
      2: return 64'h0000_0000_ffff_ffff;
      3: return 64'hffff_ffff_ffff_fffe;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Result check and receiver stalls.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: out_byte %h out_last %b", out_byte, out_last);
        fail_count++;
      end else begin
        head_result = expected_bytes.pop_front();
        if (out_byte !== head_result.data) begin
          $error("out_byte mismatch: expected %h, actual %h", head_result.data, out_byte);
          fail_count++;
        end
        if (out_last !== head_result.last) begin
          $error("out_last mismatch: expected %b, actual %b", head_result.last, out_last);
          fail_count++;
        end
      end
    end
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_enable && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Send one byte request, with an optional idle burst in front of it.
  task automatic send_byte(input logic [7:0] d, input logic l);
    byte_result_t res;
    if (idle_enable && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    res.data = xor_with_keystream(d, l);
    res.last = l;
    expected_bytes = {expected_bytes, res};
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= l;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Stop sending and wait until every expected byte has come out.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register through the configuration channel.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] v);
    apply_register(idx, v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Message of random bytes, optionally paused midway for register writes.
  task automatic send_random_message(input int len, input bit allow_split);
    int split_at;
    split_at = -1;
    if (allow_split && len > 2 && $urandom_range(0, 7) == 0) begin
      split_at = $urandom_range(1, len - 1);
    end
    for (int i = 0; i < len; i++) begin
      if (i == split_at) begin
        wait_for_idle();
        repeat ($urandom_range(1, 3)) begin
          write_register(CFG_INDEX_W'($urandom_range(0, 7)), pick_value());
        end
      end
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // Defaults after reset: all-zero key, nonce and counter.
  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'ha5, 1'b1);
    wait_for_idle();
  endtask

  // Every register at its all-ones value, and the unused indexes ignored.
  task automatic test_register_extremes();
    write_register(CFG_KEY_WORD_0, '1);
    write_register(CFG_KEY_WORD_1, '1);
    write_register(CFG_KEY_WORD_2, '1);
    write_register(CFG_KEY_WORD_3, '1);
    write_register(CFG_NONCE_VALUE, '1);
    write_register(CFG_START_COUNT, '1);
    write_register(CFG_UNUSED_6, {$urandom, $urandom});
    write_register(CFG_UNUSED_7, {$urandom, $urandom});
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5a, 1'b1);
    wait_for_idle();
  endtask

  // One-byte messages, each starting again at the start counter.
  task automatic test_single_byte_messages();
    write_register(CFG_KEY_WORD_0, 64'h0706050403020100);
    write_register(CFG_KEY_WORD_1, 64'h0f0e0d0c0b0a0908);
    write_register(CFG_KEY_WORD_2, 64'h1716151413121110);
    write_register(CFG_KEY_WORD_3, 64'h1f1e1d1c1b1a1918);
    write_register(CFG_NONCE_VALUE, 64'h4a00000000000000);
    write_register(CFG_START_COUNT, 64'd1);
    for (int i = 0; i < 4; i++) begin
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end
    wait_for_idle();
  endtask

  // Key, nonce and counter rewritten in the middle of a message.
  task automatic test_mid_message_update();
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    wait_for_idle();
    write_register(CFG_KEY_WORD_2, {$urandom, $urandom});
    write_register(CFG_NONCE_VALUE, {$urandom, $urandom});
    write_register(CFG_START_COUNT, 64'h0000_0000_ffff_ffff);
    send_byte(8'h44, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h66, 1'b1);
    send_byte(8'h77, 1'b0);
    send_byte(8'h88, 1'b1);
    wait_for_idle();
  endtask

  // Random phases of register settings and messages of mixed lengths.
  task automatic test_random_traffic();
    int start_items;
    int len;
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      idle_enable = (items_sent - start_items) < (RANDOM_ITEMS - QUIET_ITEMS);
      gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
      stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
      for (int r = 0; r < 8; r++) begin
        if ($urandom_range(0, 1) == 1) begin
          write_register(CFG_INDEX_W'(r), pick_value());
        end
      end
      repeat ($urandom_range(1, 8)) begin
        // Idle bursts stop once the quiet tail of the run is reached.
        if (items_sent - start_items < RANDOM_ITEMS) begin
          idle_enable = (items_sent - start_items) < (RANDOM_ITEMS - QUIET_ITEMS);
          case ($urandom_range(0, 9))
            6, 7: len = $urandom_range(17, 70);
            8: len = $urandom_range(60, 70);
            9: len = $urandom_range(120, 140);
            default: len = $urandom_range(1, 16);
          endcase
          send_random_message(len, 1'b1);
        end
      end
      wait_for_idle();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_single_byte_messages();
    test_mid_message_update();
    test_random_traffic();
    wait_for_idle();
    if (fail_count == 0) begin
      $display("PASS chacha20_keystream_xor_unit");
    end else begin
      $display("FAIL chacha20_keystream_xor_unit");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ckx_pkg.sv
rtl/ckx_queue.sv
rtl/ckx_front.sv
rtl/ckx_back.sv
rtl/chacha20_keystream_xor_unit.sv
tb/tb_chacha20_keystream_xor_unit.sv
